[rtl/jise_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package jise_pkg;

  // opcode encodings
  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_ICONST_LO = 8'h02;
  localparam logic [7:0] OP_ICONST_HI = 8'h08;
  localparam logic [7:0] OP_BIPUSH    = 8'h10;
  localparam logic [7:0] OP_ILOAD     = 8'h15;
  localparam logic [7:0] OP_ILOAD_0   = 8'h1A;
  localparam logic [7:0] OP_ILOAD_3   = 8'h1D;
  localparam logic [7:0] OP_ALOAD_0   = 8'h2A;
  localparam logic [7:0] OP_ALOAD_3   = 8'h2D;
  localparam logic [7:0] OP_ISTORE_0  = 8'h3B;
  localparam logic [7:0] OP_ISTORE_3  = 8'h3E;
  localparam logic [7:0] OP_ASTORE_0  = 8'h4B;
  localparam logic [7:0] OP_ASTORE_3  = 8'h4E;
  localparam logic [7:0] OP_POP       = 8'h57;
  localparam logic [7:0] OP_POP2      = 8'h58;
  localparam logic [7:0] OP_IADD      = 8'h60;
  localparam logic [7:0] OP_ISUB      = 8'h64;
  localparam logic [7:0] OP_IMUL      = 8'h68;
  localparam logic [7:0] OP_IDIV      = 8'h6C;
  localparam logic [7:0] OP_INEG      = 8'h74;
  localparam logic [7:0] OP_IAND      = 8'h7E;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DIV0  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_UNSUP = 3'd4;
  localparam logic [2:0] ST_LOCAL = 3'd5;

  typedef enum logic [3:0] {
    K_NOP, K_PUSH, K_LOAD, K_STORE, K_POP, K_POP2,
    K_ADD, K_SUB, K_MUL, K_DIV, K_AND, K_NEG, K_BAD
  } kind_e;

  // decoded instruction passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] imm;
    logic [7:0]  idx;
  } instr_t;

endpackage
`default_nettype wire

[rtl/jise_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module jise_decode
  import jise_pkg::*;
(
  input  wire logic [7:0] func_i,
  input  wire logic [7:0] operand_byte_i,
  output instr_t          instr_o
);

  // classify opcode
  always_comb begin
    instr_o.kind = K_BAD;
    instr_o.imm  = '0;
    instr_o.idx  = '0;
    if (func_i == OP_NOP) begin
      instr_o.kind = K_NOP;
    end else if (func_i >= OP_ICONST_LO && func_i <= OP_ICONST_HI) begin
      instr_o.kind = K_PUSH;
      instr_o.imm  = {24'd0, func_i} - 32'd3;
    end else if (func_i == OP_BIPUSH) begin
      instr_o.kind = K_PUSH;
      instr_o.imm  = {{24{operand_byte_i[7]}}, operand_byte_i};
    end else if (func_i == OP_ILOAD) begin
      instr_o.kind = K_LOAD;
      instr_o.idx  = operand_byte_i;
    end else if (func_i >= OP_ILOAD_0 && func_i <= OP_ILOAD_3) begin
      instr_o.kind = K_LOAD;
      instr_o.idx  = func_i - OP_ILOAD_0;
    end else if (func_i >= OP_ALOAD_0 && func_i <= OP_ALOAD_3) begin
      instr_o.kind = K_LOAD;
      instr_o.idx  = func_i - OP_ALOAD_0;
    end else if (func_i >= OP_ISTORE_0 && func_i <= OP_ISTORE_3) begin
      instr_o.kind = K_STORE;
      instr_o.idx  = func_i - OP_ISTORE_0;
    end else if (func_i >= OP_ASTORE_0 && func_i <= OP_ASTORE_3) begin
      instr_o.kind = K_STORE;
      instr_o.idx  = func_i - OP_ASTORE_0;
    end else if (func_i == OP_POP) begin
      instr_o.kind = K_POP;
    end else if (func_i == OP_POP2) begin
      instr_o.kind = K_POP2;
    end else if (func_i == OP_IADD) begin
      instr_o.kind = K_ADD;
    end else if (func_i == OP_ISUB) begin
      instr_o.kind = K_SUB;
    end else if (func_i == OP_IMUL) begin
      instr_o.kind = K_MUL;
    end else if (func_i == OP_IDIV) begin
      instr_o.kind = K_DIV;
    end else if (func_i == OP_IAND) begin
      instr_o.kind = K_AND;
    end else if (func_i == OP_INEG) begin
      instr_o.kind = K_NEG;
    end
  end

endmodule
`default_nettype wire

[rtl/jise_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
module jise_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] trial;

  // one quotient bit per cycle, restoring, on magnitudes
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[31] ? 32'd0 - dividend_i : dividend_i;
      dvs_d  = divisor_i[31] ? 32'd0 - divisor_i : divisor_i;
      neg_d  = dividend_i[31] ^ divisor_i[31];
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? 32'd0 - quo_q : quo_q;

endmodule
`default_nettype wire

[rtl/jise_execute.sv]
`timescale 1ns / 1ps
`default_nettype none
module jise_execute
  import jise_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LOCAL_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [8:0]  locals_in_use_i,
  input  wire logic        in_valid_i,
  input  wire instr_t      instr_i,
  output logic             in_ready_o,
  output logic             res_valid_o,
  output logic [2:0]       status_o,
  output logic [31:0]      top_value_o,
  output logic [6:0]       stack_depth_o,
  input  wire logic        res_ready_i
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned LW  = $clog2(LOCAL_COUNT);
  localparam int unsigned CLW = $clog2(LOCAL_COUNT + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [31:0]    top_q, top_d;   // cached top of stack
  instr_t         ins_q;
  logic [CLW-1:0] clr_q;

  // memories, read data registered
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] loc_mem [LOCAL_COUNT];
  logic [31:0] stk_rd_q, loc_rd_q;
  logic [31:0] top3_q;
  logic        stk_we, loc_we;
  logic [AW-1:0] stk_wa, stk_ra;
  logic [LW-1:0] loc_wa;
  logic [31:0]   stk_wd, loc_wd;

  logic          res_valid_q;
  logic [2:0]    status_q;
  logic [31:0]   res_top_q;
  logic [6:0]    res_depth_q;
  logic          res_load;
  logic [2:0]    res_status;

  logic [CLW-1:0] limit;
  logic           idx_bad;
  logic           div_start, div_done;
  logic [31:0]    div_q;
  logic [31:0]    mul_q;
  logic [31:0]    alu_r;

  assign limit   = (locals_in_use_i > 9'(LOCAL_COUNT)) ? CLW'(LOCAL_COUNT)
                                                       : CLW'(locals_in_use_i);
  assign idx_bad = {1'b0, ins_q.idx} >= 9'(limit);

  jise_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (stk_rd_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign in_ready_o = (state_q == S_IDLE) && !res_valid_q;

  // second operand is read in S_RD; mem read address is sp-2
  always_comb begin
    stk_ra = AW'(sp_q - SPW'(2));
  end

  // simple alu on a (below top) and b (top)
  always_comb begin
    unique case (ins_q.kind)
      K_ADD:   alu_r = stk_rd_q + top_q;
      K_SUB:   alu_r = stk_rd_q - top_q;
      K_AND:   alu_r = stk_rd_q & top_q;
      default: alu_r = stk_rd_q & top_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    top_d      = top_q;
    stk_we     = 1'b0;
    stk_wa     = AW'(sp_q);
    stk_wd     = top_q;
    loc_we     = 1'b0;
    loc_wa     = LW'(ins_q.idx);
    loc_wd     = top_q;
    res_load   = 1'b0;
    res_status = ST_OK;
    div_start  = 1'b0;
    unique case (state_q)
      S_CLR: begin
        loc_we = 1'b1;
        loc_wa = LW'(clr_q);
        loc_wd = '0;
        if (clr_q == CLW'(LOCAL_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = S_RD;
      end
      S_RD: begin
        // memory reads for load and binary operand are issued here
        state_d = S_EXEC;
      end
      S_MUL: begin
        top_d    = mul_q;
        sp_d     = sp_q - SPW'(1);
        res_load = 1'b1;
        state_d  = S_WB;
      end
      S_DIV: begin
        if (div_done) begin
          top_d    = div_q;
          sp_d     = sp_q - SPW'(1);
          res_load = 1'b1;
          state_d  = S_WB;
        end
      end
      S_WB: begin
        state_d = S_IDLE;
      end
      S_EXEC: begin
        state_d  = S_WB;
        res_load = 1'b1;
        unique case (ins_q.kind)
          K_NOP: ;
          K_PUSH, K_LOAD: begin
            if (ins_q.kind == K_LOAD && idx_bad) res_status = ST_LOCAL;
            else if (sp_q >= SPW'(STACK_DEPTH)) res_status = ST_OVER;
            else begin
              // spill the cached top into memory
              if (sp_q != '0) begin
                stk_we = 1'b1;
                stk_wa = AW'(sp_q - SPW'(1));
              end
              top_d = (ins_q.kind == K_LOAD) ? loc_rd_q : ins_q.imm;
              sp_d  = sp_q + SPW'(1);
            end
          end
          K_STORE: begin
            if (idx_bad) res_status = ST_LOCAL;
            else if (sp_q == '0) res_status = ST_UNDER;
            else begin
              // entry below the top becomes the new top
              loc_we = 1'b1;
              top_d  = stk_rd_q;
              sp_d   = sp_q - SPW'(1);
            end
          end
          K_POP: begin
            if (sp_q == '0) res_status = ST_UNDER;
            else begin
              top_d = stk_rd_q;
              sp_d  = sp_q - SPW'(1);
            end
          end
          K_POP2: begin
            if (sp_q < SPW'(2)) res_status = ST_UNDER;
            else begin
              top_d = top3_q;
              sp_d  = sp_q - SPW'(2);
            end
          end
          K_NEG: begin
            if (sp_q == '0) res_status = ST_UNDER;
            else top_d = 32'd0 - top_q;
          end
          K_ADD, K_SUB, K_AND: begin
            if (sp_q < SPW'(2)) res_status = ST_UNDER;
            else begin
              top_d = alu_r;
              sp_d  = sp_q - SPW'(1);
            end
          end
          K_MUL: begin
            if (sp_q < SPW'(2)) res_status = ST_UNDER;
            else begin
              res_load = 1'b0;
              state_d  = S_MUL;
            end
          end
          K_DIV: begin
            if (sp_q < SPW'(2)) res_status = ST_UNDER;
            else if (top_q == '0) res_status = ST_DIV0;
            else begin
              res_load  = 1'b0;
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: res_status = ST_UNSUP;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  // third entry for pop2, read alongside in S_RD at sp-3
  always_ff @(posedge clk_i) begin
    top3_q <= stk_mem[AW'(sp_q - SPW'(3))];
  end

  // stack and locals memories
  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_q <= stk_mem[stk_ra];
    if (loc_we) loc_mem[loc_wa] <= loc_wd;
    loc_rd_q <= loc_mem[LW'(ins_q.idx)];
  end

  // registered multiply
  always_ff @(posedge clk_i) begin
    mul_q <= stk_rd_q * top_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      sp_q        <= '0;
      top_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      top_q   <= top_d;
      if (state_q == S_CLR) clr_q <= clr_q + CLW'(1);
      if (res_load) res_valid_q <= 1'b1;
      else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end

  // captured item and result register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) ins_q <= instr_i;
    if (res_load) begin
      status_q    <= res_status;
      res_top_q   <= (sp_d == '0) ? 32'd0 : top_d;
      res_depth_q <= 7'(sp_d);
    end
  end

  assign res_valid_o   = res_valid_q;
  assign status_o      = status_q;
  assign top_value_o   = res_top_q;
  assign stack_depth_o = res_depth_q;

endmodule
`default_nettype wire

[rtl/jvm_int_stack_execute.sv]
`timescale 1ns / 1ps
`default_nettype none
// Integer Java bytecode stack machine. One opcode per transaction; each gives one result
// with status, top of stack and depth. The top of stack sits in a register and the rest
// of the stack and the locals in memories. An item passes read, execute, write-back
// and back to idle; imul adds a multiply state, idiv a divide state for the bit-serial
// divider. After reset the locals memory is cleared entry by entry; one transaction can
// meanwhile wait in the front queue, after which full stays high until clearing ends.
module jvm_int_stack_execute
  import jise_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LOCAL_COUNT = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         func_i,
  input  wire logic [7:0]         operand_byte_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              status_o,
  output logic signed [31:0]      top_value_o,
  output logic [6:0]              stack_depth_o,
  input  wire logic               cfg_we_i,
  input  wire logic [8:0]         cfg_wdata_i
);

  logic [8:0] locals_in_use_q;
  instr_t     dec, fq_q;
  logic       fq_valid_q, ex_ready, res_valid;
  logic [31:0] top_raw;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) locals_in_use_q <= 9'd256;
    else if (cfg_we_i) locals_in_use_q <= cfg_wdata_i;
  end

  jise_decode u_dec (
    .func_i         (func_i),
    .operand_byte_i (operand_byte_i),
    .instr_o        (dec)
  );

  // one-entry queue between front and back
  assign full = fq_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fq_valid_q <= 1'b0;
    else if (push && !full) fq_valid_q <= 1'b1;
    else if (ex_ready) fq_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (push && !full) fq_q <= dec;
  end

  jise_execute #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCAL_COUNT (LOCAL_COUNT)
  ) u_exe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .locals_in_use_i (locals_in_use_q),
    .in_valid_i      (fq_valid_q),
    .instr_i         (fq_q),
    .in_ready_o      (ex_ready),
    .res_valid_o     (res_valid),
    .status_o        (status_o),
    .top_value_o     (top_raw),
    .stack_depth_o   (stack_depth_o),
    .res_ready_i     (pop)
  );

  assign empty       = !res_valid;
  assign top_value_o = top_raw;

  // empty stack reports zero on top
  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stack_depth_o == 7'd0) |-> top_value_o == 32'sd0)
    else $error("top not zero on empty stack");
  // status code stays within the defined codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o <= ST_LOCAL)
    else $error("bad status code");

endmodule
`default_nettype wire
